// ----- rtl/adv_pkg.sv -----
// Shared types and constants for the advertising data validator.
// Parse phase encoding and AD type codes; no dependencies.
package adv_pkg;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2
    } t_phase;

    localparam logic [7:0] AD_FLAGS       = 8'h01;
    localparam logic [7:0] AD_UUID16_INC  = 8'h02;
    localparam logic [7:0] AD_UUID16_CMP  = 8'h03;
    localparam logic [7:0] AD_UUID128_INC = 8'h06;
    localparam logic [7:0] AD_UUID128_CMP = 8'h07;
    localparam logic [7:0] AD_SOL_UUID16  = 8'h14;
    localparam logic [7:0] AD_SOL_UUID128 = 8'h15;
    localparam logic [7:0] AD_SVC_DATA    = 8'h16;
    localparam logic [7:0] AD_PUB_ADDR    = 8'h17;
    localparam logic [7:0] AD_RND_ADDR    = 8'h18;
    localparam logic [7:0] AD_DEV_ADDR    = 8'h1B;

    localparam logic [7:0] FLAGS_VAL_A    = 8'h04;
    localparam logic [7:0] FLAGS_VAL_B    = 8'h05;
    localparam logic [7:0] FLAGS_VAL_C    = 8'h06;

endpackage

// ----- rtl/adv_type_rules.sv -----
// Per-type data length rules for one AD structure.
// Depends on adv_pkg for the AD type codes.
module adv_type_rules
    import adv_pkg::*;
(
    input  logic [7:0] i_ad_type,
    input  logic [7:0] i_data_len,
    output logic       o_len_ok
);

    logic [3:0] w_digit_sum;
    logic       w_mod3_zero;
    logic       w_mod6_zero;

    // 4 = 1 mod 3, so base-4 digits sum to the same residue
    assign w_digit_sum = 4'(i_data_len[1:0]) + 4'(i_data_len[3:2])
                       + 4'(i_data_len[5:4]) + 4'(i_data_len[7:6]);

    always_comb begin
        case (w_digit_sum)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12: w_mod3_zero = 1'b1;
            default:                       w_mod3_zero = 1'b0;
        endcase
    end

    assign w_mod6_zero = w_mod3_zero && !i_data_len[0];

    always_comb begin
        case (i_ad_type)
            AD_FLAGS:
                o_len_ok = (i_data_len == 8'd1);
            AD_UUID16_INC, AD_UUID16_CMP, AD_SOL_UUID16:
                o_len_ok = (i_data_len != 8'd0) && !i_data_len[0];
            AD_UUID128_INC, AD_UUID128_CMP, AD_SOL_UUID128:
                o_len_ok = (i_data_len != 8'd0) && (i_data_len[3:0] == 4'd0);
            AD_SVC_DATA:
                o_len_ok = (i_data_len >= 8'd2);
            AD_PUB_ADDR, AD_RND_ADDR, AD_DEV_ADDR:
                o_len_ok = w_mod6_zero;
            8'h04, 8'h05, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12,
            8'h19, 8'h1A, 8'h1C, 8'h1D, 8'h1E, 8'h20, 8'h21, 8'h24, 8'h3D:
                o_len_ok = 1'b0;
            default:
                o_len_ok = 1'b1;
        endcase
    end

endmodule

// ----- rtl/adv_data_validator.sv -----
// Top level of the advertising data validator: LTV parse of a byte stream.
// Depends on adv_pkg and adv_type_rules.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_stall | i_data_byte, i_last_byte
//   out     | output    | o_out_valid / i_out_stall | o_payload_ok
//
// One byte per cycle sustained while no last byte is held; its verdict is registered.
// Each byte is parsed in one pass between the input register and the state/result
// registers. Only a last byte waits on a full, stalled result register; other bytes pass.
// Synchronous active-low reset clears the parse state and both valid flags.
module adv_data_validator
    import adv_pkg::*;
#(
    parameter int MAX_PAYLOAD = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_payload_ok
);

    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 2);
    localparam int LEFT_W = $clog2(MAX_PAYLOAD);

    logic              r_in_valid;
    logic [7:0]        r_byte;
    logic              r_last;

    t_phase            r_phase,   n_phase;
    logic [LEFT_W-1:0] r_left,    n_left;
    logic              r_flags,   n_flags;
    logic              r_err,     n_err;
    logic [CNT_W-1:0]  r_count,   n_count;

    logic              r_out_valid;
    logic              r_ok,      n_ok;

    logic              w_advance;
    logic              w_in_take;
    logic [8:0]        w_room;
    logic              w_len_bad;
    logic              w_type_ok;
    logic [LEFT_W-1:0] w_left_dec;

    adv_type_rules u_rules (
        .i_ad_type  (r_byte),
        .i_data_len (8'(r_left)),
        .o_len_ok   (w_type_ok)
    );

    assign w_advance  = r_in_valid && (!r_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign w_room     = (r_count < CNT_W'(MAX_PAYLOAD))
                      ? (9'(MAX_PAYLOAD - 1) - 9'(r_count)) : 9'd0;
    assign w_len_bad  = (r_byte == 8'd0) || ({1'b0, r_byte} > w_room);
    assign w_left_dec = (r_left != '0) ? (r_left - LEFT_W'(1)) : r_left;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (!r_err) begin
            case (r_phase)
                PH_LEN:  if (!w_len_bad) n_phase = PH_TYPE;
                PH_TYPE: if (w_type_ok) n_phase = (r_left != '0) ? PH_DATA : PH_LEN;
                PH_DATA: if (w_left_dec == '0) n_phase = PH_LEN;
                default: n_phase = r_phase;
            endcase
        end
    end

    // remaining parse state and verdict
    always_comb begin
        n_left  = r_left;
        n_flags = r_flags;
        n_err   = r_err;
        n_count = (r_count <= CNT_W'(MAX_PAYLOAD)) ? (r_count + CNT_W'(1)) : r_count;
        if (!r_err) begin
            case (r_phase)
                PH_LEN: begin
                    if (w_len_bad) n_err = 1'b1;
                    else           n_left = LEFT_W'(r_byte - 8'd1);
                end
                PH_TYPE: begin
                    if (!w_type_ok) n_err = 1'b1;
                    else            n_flags = (r_byte == AD_FLAGS);
                end
                PH_DATA: begin
                    if (r_flags && r_byte != FLAGS_VAL_A && r_byte != FLAGS_VAL_B
                        && r_byte != FLAGS_VAL_C)
                        n_err = 1'b1;
                    n_flags = 1'b0;
                    n_left  = w_left_dec;
                end
                default: n_err = 1'b1;
            endcase
        end
        n_ok = !n_err && (n_phase == PH_LEN) && (n_count >= CNT_W'(2))
             && (n_count <= CNT_W'(MAX_PAYLOAD));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN;
            r_left  <= '0;
            r_flags <= 1'b0;
            r_err   <= 1'b0;
            r_count <= '0;
        end else if (w_advance) begin
            if (r_last) begin
                r_phase <= PH_LEN;
                r_left  <= '0;
                r_flags <= 1'b0;
                r_err   <= 1'b0;
                r_count <= '0;
            end else begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_flags <= n_flags;
                r_err   <= n_err;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_last) begin
            r_ok <= n_ok;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_payload_ok = r_ok;

endmodule

// ----- rtl/adv_checker.sv -----
// Port-level checks for the advertising data validator.
// Bound to adv_data_validator; no package dependency.
module adv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_data_byte,
    input logic       i_last_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_payload_ok
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked verdict");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_data_byte)
            && $stable(i_last_byte))
        else $error("stalled input transaction changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled verdict dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_payload_ok))
        else $error("stalled verdict changed");

endmodule

bind adv_data_validator adv_checker u_adv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_data_byte  (i_data_byte),
    .i_last_byte  (i_last_byte),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_payload_ok (o_payload_ok)
);
